// ===== hw/rtl/pwl_pkg.sv =====
// Shared types and constants of the piecewise linear lookup unit.
// Depends on nothing; pwl_front, pwl_div, pwl_back and the top level import it.
`timescale 1ns / 1ps

package pwl_pkg;

	// Field widths fixed by the item format
	localparam int VAL_W    = 32;
	localparam int ENTRY_W  = 4;
	localparam int CFG_W    = 5;
	localparam int SEG_W    = 5;

	// Blend arithmetic: 32x33 products, their sum, and the magnitude of the sum
	localparam int PROD_W   = 2 * VAL_W + 1;
	localparam int NUM_W    = 2 * VAL_W + 2;
	localparam int MAG_W    = 2 * VAL_W + 1;

	localparam int DEFAULT_MAX_POINTS = 16;
	localparam int QUEUE_DEPTH        = 2;

	// Item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// Register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;

	// Command passed from the front end to the back end
	typedef struct packed {
		logic                    is_eval;
		logic [ENTRY_W-1:0]      idx;
		logic signed [VAL_W-1:0] val_a;  // limit for a load, query for an evaluate
		logic signed [VAL_W-1:0] val_b;  // score for a load
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SCAN_END,
		BK_FETCH_LO,
		BK_FETCH_HI,
		BK_MUL1,
		BK_MUL2,
		BK_ADD,
		BK_DIV_GO,
		BK_DIV,
		BK_RESULT
	} back_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_LOAD,
		DV_RUN,
		DV_DONE
	} div_state_t;

endpackage

// ===== hw/rtl/pwl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pwl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/pwl_front.sv =====
// Front end: accepts items, drops out-of-range loads and queues commands.
// Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_front #(
	parameter int MAX_POINTS = pwl_pkg::DEFAULT_MAX_POINTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            kind,
	input  logic [pwl_pkg::ENTRY_W-1:0]     entry_index,
	input  logic signed [pwl_pkg::VAL_W-1:0] limit_value,
	input  logic signed [pwl_pkg::VAL_W-1:0] score_value,
	input  logic signed [pwl_pkg::VAL_W-1:0] query_value,
	output logic                            q_valid,
	output pwl_pkg::cmd_t                   q_head,
	input  logic                            q_pop
);
	import pwl_pkg::*;

	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              keep;
	logic              push;
	cmd_t              cmd;

	// Classify the item; a load beyond the table is taken and dropped
	always_comb begin
		keep        = (kind == KIND_EVAL) || (32'(entry_index) < MAX_POINTS);
		cmd.is_eval = (kind == KIND_EVAL);
		cmd.idx     = entry_index;
		cmd.val_a   = (kind == KIND_EVAL) ? query_value : limit_value;
		cmd.val_b   = score_value;
	end

	assign req_ready = (fill_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push      = req_valid && req_ready && keep;
	assign q_valid   = (fill_q != '0);
	assign q_head    = slot_q[rd_ptr_q];

	// Store queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue fill level beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_push_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill level missed a push");

endmodule

// ===== hw/rtl/pwl_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating to the value range.
// Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [pwl_pkg::NUM_W-1:0] num,
	input  logic [pwl_pkg::VAL_W-1:0]        den,
	output logic                             done,
	output logic signed [pwl_pkg::VAL_W-1:0] quo
);
	import pwl_pkg::*;

	localparam int STEP_W = $clog2(VAL_W);

	div_state_t          state_q;
	div_state_t          state_d;
	logic                neg_q;
	logic [MAG_W-1:0]    mag_q;
	logic [VAL_W-1:0]    den_q;
	logic [VAL_W:0]      rem_q;
	logic [VAL_W-1:0]    quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                ovf_q;
	logic                ovf;
	logic                last;
	logic [VAL_W:0]      trial;
	logic                ge;
	logic [VAL_W-1:0]    lim;
	logic [VAL_W-1:0]    sat_mag;

	// Quotient would not fit in VAL_W bits
	assign ovf   = (mag_q[MAG_W-1:VAL_W] >= {1'b0, den_q});
	assign last  = (step_q == STEP_W'(VAL_W - 1));
	assign trial = {rem_q[VAL_W-1:0], quo_q[VAL_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					state_d = DV_LOAD;
				end
			end
			DV_LOAD: state_d = ovf ? DV_DONE : DV_RUN;
			DV_RUN: begin
				if (last) begin
					state_d = DV_DONE;
				end
			end
			DV_DONE: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		done = (state_q == DV_DONE);
	end

	// Saturate and apply sign
	always_comb begin
		lim     = neg_q ? {1'b1, {(VAL_W - 1){1'b0}}} : {1'b0, {(VAL_W - 1){1'b1}}};
		sat_mag = (ovf_q || (quo_q > lim)) ? lim : quo_q;
		quo     = neg_q ? -sat_mag : sat_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: take magnitude, then shift and subtract
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					neg_q <= num[NUM_W-1];
					mag_q <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
					den_q <= den;
				end
			end
			DV_LOAD: begin
				ovf_q  <= ovf;
				rem_q  <= mag_q[MAG_W-1:VAL_W];
				quo_q  <= mag_q[VAL_W-1:0];
				step_q <= '0;
			end
			DV_RUN: begin
				rem_q  <= ge ? (trial - {1'b0, den_q}) : trial;
				quo_q  <= {quo_q[VAL_W-2:0], ge};
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == DV_IDLE))
		else $error("divider started while busy");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DV_RUN) |-> (rem_q < {1'b0, den_q}))
		else $error("partial remainder not below divisor");
	a_run_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DV_RUN) |-> (den_q != '0))
		else $error("division by zero in progress");

endmodule

// ===== hw/rtl/pwl_back.sv =====
// Back end: owns the breakpoint RAM, scans limits, blends scores, holds result.
// Depends on pwl_pkg, pwl_ram and pwl_div.
`timescale 1ns / 1ps

module pwl_back #(
	parameter int MAX_POINTS = pwl_pkg::DEFAULT_MAX_POINTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pwl_pkg::CFG_W-1:0]        point_count,
	input  logic                             q_valid,
	input  pwl_pkg::cmd_t                    q_head,
	output logic                             q_pop,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic signed [pwl_pkg::VAL_W-1:0] score,
	output logic [pwl_pkg::SEG_W-1:0]        segment,
	output logic                             bad_interval
);
	import pwl_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int PC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int ENT_W = 2 * VAL_W;

	back_state_t              state_q;
	back_state_t              state_d;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         scan_q;
	logic                     cmp_s1;
	logic signed [VAL_W-1:0]  query_q;
	logic signed [VAL_W-1:0]  lo_l_q;
	logic signed [VAL_W-1:0]  lo_s_q;
	logic signed [VAL_W:0]    dq_lo_q;
	logic signed [VAL_W:0]    dq_hi_q;
	logic [VAL_W-1:0]         den_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [NUM_W-1:0]  acc_q;
	logic signed [VAL_W-1:0]  res_score_q;
	logic                     res_bad_q;
	logic                     rsp_valid_q;
	logic signed [VAL_W-1:0]  score_q;
	logic [SEG_W-1:0]         segment_q;
	logic                     bad_q;

	logic [PC_W-1:0]          pc_ext;
	logic [CNT_W-1:0]         n_next;
	logic                     clamp;
	logic                     scan_last;
	logic                     out_free;
	logic signed [VAL_W:0]    den_w;
	logic                     den_pos;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [ENT_W-1:0]         ram_wdata;
	logic [IDX_W-1:0]         ram_raddr;
	logic [ENT_W-1:0]         ram_rdata;
	logic signed [VAL_W-1:0]  rd_limit;
	logic signed [VAL_W-1:0]  rd_score;
	logic                     div_start;
	logic                     div_done;
	logic signed [VAL_W-1:0]  div_quo;
	logic                     out_load;

	pwl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pwl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Clamp the point count to the table depth
	assign pc_ext = PC_W'(point_count);
	assign n_next = (pc_ext >= PC_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_ext);

	assign rd_limit  = ram_rdata[ENT_W-1:VAL_W];
	assign rd_score  = ram_rdata[VAL_W-1:0];
	assign clamp     = (cnt_q == '0) || (cnt_q == n_q);
	assign scan_last = (CNT_W'(scan_q) == (n_q - 1'b1));
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign den_w     = rd_limit - lo_l_q;
	assign den_pos   = !den_w[VAL_W] && (den_w != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_head.is_eval) begin
					state_d = (n_next == '0) ? BK_RESULT : BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_last) begin
					state_d = BK_SCAN_END;
				end
			end
			BK_SCAN_END: state_d = BK_FETCH_LO;
			BK_FETCH_LO: state_d = BK_FETCH_HI;
			BK_FETCH_HI: state_d = clamp ? BK_RESULT : BK_MUL1;
			BK_MUL1:     state_d = den_pos ? BK_MUL2 : BK_RESULT;
			BK_MUL2:     state_d = BK_ADD;
			BK_ADD:      state_d = BK_DIV_GO;
			BK_DIV_GO:   state_d = BK_DIV;
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_RESULT;
				end
			end
			BK_RESULT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs: queue pop, RAM ports, divider start, result load
	always_comb begin
		q_pop     = (state_q == BK_IDLE) && q_valid;
		ram_we    = (state_q == BK_IDLE) && q_valid && !q_head.is_eval;
		ram_waddr = IDX_W'(q_head.idx);
		ram_wdata = {q_head.val_a, q_head.val_b};
		div_start = (state_q == BK_DIV_GO);
		out_load  = (state_q == BK_RESULT) && out_free;
		case (state_q)
			BK_FETCH_LO: ram_raddr = (cnt_q == '0) ? '0 : IDX_W'(cnt_q - 1'b1);
			BK_FETCH_HI: ram_raddr = IDX_W'(cnt_q);
			default:     ram_raddr = scan_q;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			n_q         <= '0;
			cnt_q       <= '0;
			cmp_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == BK_SCAN);
			if (q_pop && q_head.is_eval) begin
				n_q   <= n_next;
				cnt_q <= '0;
			end else if (cmp_s1 && (rd_limit <= query_q)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_head.is_eval) begin
					query_q     <= q_head.val_a;
					scan_q      <= '0;
					res_score_q <= '0;
					res_bad_q   <= 1'b0;
				end
			end
			BK_SCAN: scan_q <= scan_q + 1'b1;
			BK_FETCH_HI: begin
				// lower entry is on the read port now
				lo_l_q      <= rd_limit;
				lo_s_q      <= rd_score;
				dq_lo_q     <= query_q - rd_limit;
				res_score_q <= rd_score;
			end
			BK_MUL1: begin
				den_q   <= den_w[VAL_W-1:0];
				dq_hi_q <= rd_limit - query_q;
				prod_q  <= rd_score * dq_lo_q;
				if (!den_pos) begin
					res_bad_q <= 1'b1;
				end
			end
			BK_MUL2: begin
				acc_q  <= NUM_W'(prod_q);
				prod_q <= lo_s_q * dq_hi_q;
			end
			BK_ADD: acc_q <= acc_q + NUM_W'(prod_q);
			BK_DIV: begin
				if (div_done) begin
					res_score_q <= div_quo;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			score_q   <= res_score_q;
			segment_q <= SEG_W'(cnt_q);
			bad_q     <= res_bad_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign score        = score_q;
	assign segment      = segment_q;
	assign bad_interval = bad_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= n_q)
		else $error("limit count exceeds active points");
	a_scan_points: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (n_q != '0))
		else $error("scan with no active points");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV_GO) |-> (den_q != '0))
		else $error("divider started with zero interval");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten");

endmodule

// ===== hw/rtl/piecewise_linear_lookup_unit.sv =====
// Piecewise linear lookup unit: table load and evaluate, one item at a time in the back end.
// Loads are written to the table when the back end takes them from the queue. An evaluate
// is either interpolated, flagged on a non-positive interval, clamped, or answered without a
// scan when there are no points. While results are taken, the pace is set by the limit scan
// (one entry a cycle) and the divider (one bit a cycle); a two-entry queue buffers arrivals.
// Reset clears point_count, queue and control.
`timescale 1ns / 1ps

module piecewise_linear_lookup_unit #(
	parameter int MAX_POINTS = pwl_pkg::DEFAULT_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                kind,
	input  logic [pwl_pkg::ENTRY_W-1:0]         entry_index,
	input  logic signed [pwl_pkg::VAL_W-1:0]    limit_value,
	input  logic signed [pwl_pkg::VAL_W-1:0]    score_value,
	input  logic signed [pwl_pkg::VAL_W-1:0]    query_value,
	// result channel
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [pwl_pkg::VAL_W-1:0]    score,
	output logic [pwl_pkg::SEG_W-1:0]           segment,
	output logic                                bad_interval,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pwl_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [pwl_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [pwl_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import pwl_pkg::*;

	logic [CFG_W-1:0]     point_count_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_we;
	logic                 q_valid;
	cmd_t                 q_head;
	logic                 q_pop;

	// Register decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_we  = psel && penable && pwrite;
	assign prdata  = (reg_idx == REG_POINT_COUNT) ? APB_DATA_W'(point_count_q) : '0;

	// Hold the point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we && (reg_idx == REG_POINT_COUNT)) begin
			point_count_q <= pwdata[CFG_W-1:0];
		end
	end

	pwl_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.kind        (kind),
		.entry_index (entry_index),
		.limit_value (limit_value),
		.score_value (score_value),
		.query_value (query_value),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	pwl_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_count  (point_count_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.score        (score),
		.segment      (segment),
		.bad_interval (bad_interval)
	);

endmodule
